>>> src/svm_pkg.sv
`default_nettype none

package svm_pkg;

  // Command codes as they arrive on the input
  localparam logic [2:0] CMD_TICK = 3'd0;
  localparam logic [2:0] CMD_LOAD = 3'd1;
  localparam logic [2:0] CMD_PLAY = 3'd2;
  localparam logic [2:0] CMD_LOOP = 3'd3;
  localparam logic [2:0] CMD_STOP = 3'd4;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SLOT  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_ZERO_LEN = 2'd3
  } status_e;

  // Classified operation handed from the front to the back
  typedef enum logic [2:0] {
    OP_TICK,
    OP_LOAD,
    OP_PLAY,
    OP_LOOP,
    OP_STOP,
    OP_ZERO_LEN,
    OP_BAD_STOP,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [2:0]         command;
    logic [15:0]        address;
    logic [16:0]        wave_length;
    logic signed [31:0] sample_value;
    logic [1:0]         slot_select;
  } svm_in_t;

  typedef struct packed {
    logic signed [31:0] mixed_sample;
    logic [1:0]         slot_taken;
    logic [1:0]         status;
    logic [3:0]         active_voices;
  } svm_out_t;

  typedef struct packed {
    op_e                op;
    logic [15:0]        address;
    logic [16:0]        wave_length;
    logic signed [31:0] sample_value;
    logic [1:0]         slot_select;
  } svm_cmd_t;

endpackage

`default_nettype wire

>>> src/svm_front.sv
`default_nettype none

module svm_front import svm_pkg::*; #(
  parameter int unsigned SLOTS_PER_KIND = 4
) (
  input  svm_in_t  item_i,
  input  logic     push_i,
  output logic     full_o,
  output logic     q_push_o,
  input  logic     q_full_i,
  output svm_cmd_t cmd_o
);

  // Accept whenever the command queue has room
  assign full_o   = q_full_i;
  assign q_push_o = push_i && !q_full_i;

  // Classify the item; flag zero length and out-of-range stops here
  always_comb begin
    cmd_o.address      = item_i.address;
    cmd_o.wave_length  = item_i.wave_length;
    cmd_o.sample_value = item_i.sample_value;
    cmd_o.slot_select  = item_i.slot_select;
    unique case (item_i.command)
      CMD_TICK: cmd_o.op = OP_TICK;
      CMD_LOAD: cmd_o.op = OP_LOAD;
      CMD_PLAY: cmd_o.op = (item_i.wave_length == 17'd0) ? OP_ZERO_LEN : OP_PLAY;
      CMD_LOOP: cmd_o.op = (item_i.wave_length == 17'd0) ? OP_ZERO_LEN : OP_LOOP;
      CMD_STOP: cmd_o.op = (32'(item_i.slot_select) < SLOTS_PER_KIND) ? OP_STOP
                                                                       : OP_BAD_STOP;
      default:  cmd_o.op = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

>>> src/svm_queue.sv
`default_nettype none

module svm_queue import svm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  svm_cmd_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output svm_cmd_t data_o
);

  svm_cmd_t   entry_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = entry_q[rd_ptr_q];

  // Advance pointers and count on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Hold queued commands
  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= data_i;
  end

endmodule

`default_nettype wire

>>> src/svm_back.sv
`default_nettype none

module svm_back import svm_pkg::*; #(
  parameter int unsigned SLOTS_PER_KIND = 4,
  parameter int unsigned STORE_DEPTH    = 65536
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  input  svm_cmd_t cmd_i,
  output logic     cmd_pop_o,
  output logic     result_valid_o,
  input  logic     result_pop_i,
  output svm_out_t result_o
);

  localparam int unsigned SW     = (SLOTS_PER_KIND > 1) ? $clog2(SLOTS_PER_KIND) : 1;
  localparam int unsigned VW     = SW + 1;
  localparam int unsigned AW     = $clog2(STORE_DEPTH);
  localparam logic [VW-1:0] V_LAST = VW'(2 * SLOTS_PER_KIND - 1);
  // Reciprocal for exact truncating division of a 32-bit magnitude
  localparam int unsigned DIV_L  = $clog2(SLOTS_PER_KIND);
  localparam int unsigned DIV_S  = 32 + DIV_L;
  localparam int unsigned PW     = DIV_S + 32;
  localparam logic [63:0] DIV_M  =
    ((64'd1 << DIV_S) + 64'(SLOTS_PER_KIND) - 64'd1) / 64'(SLOTS_PER_KIND);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD_MUL,
    S_LOAD_WR,
    S_TICK,
    S_TICK_TAIL,
    S_FINISH
  } state_e;

  state_e state_q;

  // Voice slots
  logic [SLOTS_PER_KIND-1:0] os_act_q, lp_act_q;
  logic [15:0] os_start_q [SLOTS_PER_KIND];
  logic [16:0] os_len_q   [SLOTS_PER_KIND];
  logic [16:0] os_pos_q   [SLOTS_PER_KIND];
  logic [15:0] lp_start_q [SLOTS_PER_KIND];
  logic [16:0] lp_len_q   [SLOTS_PER_KIND];
  logic [16:0] lp_pos_q   [SLOTS_PER_KIND];
  logic [3:0]  cnt_q;

  // Working registers
  svm_cmd_t      cur_q;
  logic [VW-1:0] v_q;
  logic          hit_q;
  logic [31:0]   acc_q;
  logic [PW-1:0] prod_q;
  logic          neg_q;
  logic [1:0]    taken_q;
  status_e       status_q;
  svm_out_t      res_q;
  logic          res_valid_q;

  // Sample store
  logic [31:0]   store_mem [STORE_DEPTH];
  logic [31:0]   rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata;

  logic          res_free;
  logic          free_found;
  logic [SW-1:0] free_idx;
  logic [SW-1:0] sel_idx;
  logic [SW-1:0] slot;
  logic          voice_act;
  logic [15:0]   v_start;
  logic [16:0]   v_len, v_pos, v_next;
  logic          at_end;
  logic [31:0]   abs_val;
  logic [31:0]   quot;

  assign cmd_pop_o      = (state_q == S_IDLE) && cmd_valid_i;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;
  assign res_free       = !res_valid_q || result_pop_i;
  assign sel_idx        = SW'(cur_q.slot_select);

  // Find the lowest free slot of the commanded kind
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS_PER_KIND - 1; i >= 0; i--) begin
      if (cur_q.op == OP_PLAY ? !os_act_q[i] : !lp_act_q[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  // Select the voice visited this cycle: one-shot slot before loop slot
  assign slot = v_q[VW-1:1];
  always_comb begin
    if (v_q[0]) begin
      voice_act = lp_act_q[slot];
      v_start   = lp_start_q[slot];
      v_len     = lp_len_q[slot];
      v_pos     = lp_pos_q[slot];
    end else begin
      voice_act = os_act_q[slot];
      v_start   = os_start_q[slot];
      v_len     = os_len_q[slot];
      v_pos     = os_pos_q[slot];
    end
  end
  assign v_next    = v_pos + 17'd1;
  assign at_end    = (v_next == v_len);
  assign mem_raddr = AW'(18'(v_start) + 18'(v_pos));

  // Load path: magnitude, reciprocal product, signed quotient
  assign abs_val   = cur_q.sample_value[31] ? (~cur_q.sample_value + 32'd1)
                                            : cur_q.sample_value;
  assign quot      = prod_q[DIV_S +: 32];
  assign mem_we    = (state_q == S_LOAD_WR);
  assign mem_waddr = AW'(cur_q.address);
  assign mem_wdata = neg_q ? (~quot + 32'd1) : quot;

  always_ff @(posedge clk_i) begin
    if (mem_we) store_mem[mem_waddr] <= mem_wdata;
    rdata_q <= store_mem[mem_raddr];
  end

  // Raise the result flag when a result is written; drop it on its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= ((state_q == S_FINISH) && res_free) ||
                     (res_valid_q && !result_pop_i);
    end
  end

  // Sequencer and slot occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      os_act_q    <= '0;
      lp_act_q    <= '0;
      cnt_q       <= 4'd0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            unique case (cmd_i.op)
              OP_TICK: state_q <= S_TICK;
              OP_LOAD: state_q <= S_LOAD_MUL;
              default: state_q <= S_EXEC;
            endcase
          end
        end
        S_EXEC: begin
          unique case (cur_q.op)
            OP_PLAY: begin
              if (free_found) begin
                os_act_q[free_idx] <= 1'b1;
                cnt_q              <= cnt_q + 4'd1;
              end
            end
            OP_LOOP: begin
              if (free_found) begin
                lp_act_q[free_idx] <= 1'b1;
                cnt_q              <= cnt_q + 4'd1;
              end
            end
            OP_STOP: begin
              if (lp_act_q[sel_idx]) begin
                lp_act_q[sel_idx] <= 1'b0;
                cnt_q             <= cnt_q - 4'd1;
              end
            end
            default: ;
          endcase
          state_q <= S_FINISH;
        end
        S_LOAD_MUL: state_q <= S_LOAD_WR;
        S_LOAD_WR:  state_q <= S_FINISH;
        S_TICK: begin
          // drop a one-shot voice after its last sample
          if (voice_act && at_end && !v_q[0]) begin
            os_act_q[slot] <= 1'b0;
            cnt_q          <= cnt_q - 4'd1;
          end
          if (v_q == V_LAST) state_q <= S_TICK_TAIL;
        end
        S_TICK_TAIL: state_q <= S_FINISH;
        S_FINISH: begin
          if (res_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cur_q    <= cmd_i;
          v_q      <= '0;
          hit_q    <= 1'b0;
          acc_q    <= 32'd0;
          taken_q  <= 2'd0;
          status_q <= ST_OK;
        end
      end
      S_EXEC: begin
        unique case (cur_q.op)
          OP_PLAY: begin
            if (free_found) begin
              os_start_q[free_idx] <= cur_q.address;
              os_len_q[free_idx]   <= cur_q.wave_length;
              os_pos_q[free_idx]   <= 17'd0;
              taken_q              <= 2'(free_idx);
            end else begin
              status_q <= ST_NO_SLOT;
            end
          end
          OP_LOOP: begin
            if (free_found) begin
              lp_start_q[free_idx] <= cur_q.address;
              lp_len_q[free_idx]   <= cur_q.wave_length;
              lp_pos_q[free_idx]   <= 17'd0;
              taken_q              <= 2'(free_idx);
            end else begin
              status_q <= ST_NO_SLOT;
            end
          end
          OP_STOP: begin
            if (!lp_act_q[sel_idx]) status_q <= ST_EMPTY;
          end
          OP_ZERO_LEN: status_q <= ST_ZERO_LEN;
          OP_BAD_STOP: status_q <= ST_EMPTY;
          default: ;
        endcase
      end
      S_LOAD_MUL: begin
        prod_q <= PW'(abs_val) * PW'(DIV_M);
        neg_q  <= cur_q.sample_value[31];
      end
      S_TICK: begin
        hit_q <= voice_act;
        if (hit_q) acc_q <= acc_q + rdata_q;
        // advance the visited voice; wrap at its length
        if (voice_act) begin
          if (v_q[0]) lp_pos_q[slot] <= at_end ? 17'd0 : v_next;
          else        os_pos_q[slot] <= at_end ? 17'd0 : v_next;
        end
        v_q <= v_q + VW'(1);
      end
      S_TICK_TAIL: begin
        if (hit_q) acc_q <= acc_q + rdata_q;
      end
      S_FINISH: begin
        if (res_free) begin
          res_q.mixed_sample  <= acc_q;
          res_q.slot_taken    <= taken_q;
          res_q.status        <= status_q;
          res_q.active_voices <= cnt_q;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> src/sample_voice_mixer.sv
`default_nettype none

// Wavetable sample playback mixer with SLOTS_PER_KIND one-shot and
// SLOTS_PER_KIND looping voices over one sample store of STORE_DEPTH words
// (a power of two; store addresses wrap). Items enter a two-deep command
// queue and are then carried out one at a time by a sequencer that owns the
// voice slots and the store. A tick visits every voice slot in turn through
// the single store read port; a load multiplies the magnitude by the
// reciprocal, then writes the signed quotient to the store; play, loop and
// stop pass through the execute state. A finished result waits in an output
// register while the next item is already being worked on; the sequencer
// stalls only when it has a second result and the first is still unread.
// Store entries are undefined until loaded and there is no clearing pass.
module sample_voice_mixer import svm_pkg::*; #(
  parameter int unsigned SLOTS_PER_KIND = 4,
  parameter int unsigned STORE_DEPTH    = 65536
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  svm_in_t  item_i,
  output logic     empty,
  input  logic     pop,
  output svm_out_t result_o
);

  logic     q_push, q_full, q_valid, q_pop;
  svm_cmd_t q_in, q_out;
  logic     res_valid;

  // Classify incoming items
  svm_front #(
    .SLOTS_PER_KIND(SLOTS_PER_KIND)
  ) u_front (
    .item_i   (item_i),
    .push_i   (push),
    .full_o   (full),
    .q_push_o (q_push),
    .q_full_i (q_full),
    .cmd_o    (q_in)
  );

  // Decouple the front from the sequencer
  svm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  // Carry out commands over the voice slots and store
  svm_back #(
    .SLOTS_PER_KIND(SLOTS_PER_KIND),
    .STORE_DEPTH   (STORE_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (q_valid),
    .cmd_i          (q_out),
    .cmd_pop_o      (q_pop),
    .result_valid_o (res_valid),
    .result_pop_i   (pop && res_valid),
    .result_o       (result_o)
  );

  assign empty = !res_valid;

  // A flagged command never claims a slot
  a_flag_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.status != ST_OK) |-> (result_o.slot_taken == 2'd0))
    else $error("slot reported on a flagged result");

  // A flagged command is never a tick, so it carries no mix
  a_flag_no_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.status != ST_OK) |-> (result_o.mixed_sample == 32'sd0))
    else $error("mix reported on a flagged result");

endmodule

`default_nettype wire
